### rtl/core/udpfb_pkg.sv
// Shared types, constants and helpers for the UDP/IPv4 frame builder.
// No dependencies; imported by the front end, the back end and the top level.
package udpfb_pkg;

    // Frame layout
    localparam int HDR_BYTES = 42;
    localparam logic [5:0] HDR_LAST_IDX = 6'(HDR_BYTES - 1);

    // Field widths
    localparam int LEN_W      = 11;
    localparam int OFF_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Request kinds on the input side
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_WRITE       = 2'd0;
    localparam logic [1:0] ST_NOT_ENABLED = 2'd1;
    localparam logic [1:0] ST_TOO_LONG    = 2'd2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_MAC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_MAC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_IP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_PORT  = 3'd4;

    // Protocol constants
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL     = 8'h45;
    localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
    localparam logic [7:0]  IP_TTL         = 8'd64;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
    localparam logic [15:0] CKSUM_ZERO_TX  = 16'hFFFF;
    localparam logic [31:0] IP_BROADCAST   = 32'hFFFF_FFFF;
    localparam logic [47:0] MAC_BROADCAST  = 48'hFFFF_FFFF_FFFF;
    // Fixed words of the IPv4 header sum: version/IHL, flags, TTL/protocol
    localparam logic [15:0] IP_SUM_FIXED   =
        {IP_VER_IHL, 8'h00} + IP_FLAGS_DF + {IP_TTL, IP_PROTO_UDP};

    // Queue entry operations
    typedef enum logic [2:0] {
        OP_WRITE,
        OP_WRITE_HDR,
        OP_HDR,
        OP_REJ_DIS,
        OP_REJ_LONG
    } t_op;

    // Configuration registers
    typedef struct packed {
        logic        enable;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [15:0] src_port;
    } t_cfg;

    // One queued job for the back end, with the header snapshot it may need
    typedef struct packed {
        t_op              op;
        logic [OFF_W-1:0] offset;
        logic [7:0]       value;
        logic [31:0]      dst_ip;
        logic [15:0]      dst_port;
        logic [LEN_W-1:0] len;
        logic [15:0]      psum;
    } t_entry;

    // One's-complement 16-bit add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

### rtl/core/udpfb_fifo.sv
// Small register queue between the front and back ends of the frame builder.
// Generic width and depth; no package dependencies.
module udpfb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("fill count missed a push");

endmodule

### rtl/core/udpfb_front.sv
// Front end: accepts requests, tracks the open frame and the payload checksum,
// and queues at most one job per request. Depends on udpfb_pkg.
module udpfb_front
    import udpfb_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = 1472,
    parameter int FRAME_MAX_BYTES   = 1514
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_kind,
    input  logic [31:0]      i_dest_ip,
    input  logic [15:0]      i_dest_port,
    input  logic [LEN_W-1:0] i_payload_length,
    input  logic [7:0]       i_payload_byte,
    input  logic             i_enable,
    output logic             o_push,
    output t_entry           o_entry
);
    logic             r_open, n_open;
    logic [31:0]      r_dip, n_dip;
    logic [15:0]      r_dport, n_dport;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_bytes, n_bytes;
    logic [15:0]      r_acc, n_acc;
    logic [7:0]       r_pend, n_pend;

    logic             too_long;
    logic [15:0]      fin_sum;

    // length checks against both limits
    assign too_long = ({1'b0, i_payload_length} > 12'(MAX_PAYLOAD_BYTES))
                   || (({1'b0, i_payload_length} + 12'(HDR_BYTES)) > 12'(FRAME_MAX_BYTES));

    // classify the request and update frame state
    always_comb begin
        n_open  = r_open;
        n_dip   = r_dip;
        n_dport = r_dport;
        n_len   = r_len;
        n_bytes = r_bytes;
        n_acc   = r_acc;
        n_pend  = r_pend;
        fin_sum = r_acc;
        o_push  = 1'b0;

        o_entry.op       = OP_WRITE;
        o_entry.offset   = OFF_W'(HDR_BYTES) + r_bytes;
        o_entry.value    = i_payload_byte;
        o_entry.dst_ip   = r_dip;
        o_entry.dst_port = r_dport;
        o_entry.len      = r_len;
        o_entry.psum     = r_acc;

        if (i_accept) begin
            if (i_kind == KIND_START) begin
                n_open = 1'b0;
                if (!i_enable) begin
                    o_push     = 1'b1;
                    o_entry.op = OP_REJ_DIS;
                end else if (too_long) begin
                    o_push     = 1'b1;
                    o_entry.op = OP_REJ_LONG;
                end else begin
                    n_dip   = i_dest_ip;
                    n_dport = i_dest_port;
                    n_len   = i_payload_length;
                    n_bytes = '0;
                    n_acc   = '0;
                    n_pend  = '0;
                    n_open  = (i_payload_length != '0);
                    // empty payload: header goes out at once
                    if (i_payload_length == '0) begin
                        o_push           = 1'b1;
                        o_entry.op       = OP_HDR;
                        o_entry.dst_ip   = i_dest_ip;
                        o_entry.dst_port = i_dest_port;
                        o_entry.len      = '0;
                        o_entry.psum     = '0;
                    end
                end
            end else if (r_open) begin
                o_push = 1'b1;
                if (!r_bytes[0]) begin
                    n_pend  = i_payload_byte;
                    fin_sum = oc_add(r_acc, {i_payload_byte, 8'h00});
                end else begin
                    n_acc   = oc_add(r_acc, {r_pend, i_payload_byte});
                    fin_sum = n_acc;
                end
                n_bytes = r_bytes + 1'b1;
                // last payload byte closes the frame
                if (n_bytes >= r_len) begin
                    o_entry.op   = OP_WRITE_HDR;
                    o_entry.psum = fin_sum;
                    n_open       = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else begin
            r_open <= n_open;
        end
        r_dip   <= n_dip;
        r_dport <= n_dport;
        r_len   <= n_len;
        r_bytes <= n_bytes;
        r_acc   <= n_acc;
        r_pend  <= n_pend;
    end

    a_open_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_bytes < r_len))
        else $error("open frame has already received all its bytes");

    a_push_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_accept)
        else $error("job queued without an accepted request");

    a_hdr_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.op == OP_WRITE_HDR) |=> !r_open)
        else $error("frame still open after header job");

endmodule

### rtl/core/udpfb_back.sv
// Back end: drains the job queue into the output register, and expands
// header jobs into 42 byte writes with both checksums. Depends on udpfb_pkg.
module udpfb_back
    import udpfb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_empty,
    input  t_entry           i_entry,
    output logic             o_pop,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output logic [1:0]       o_status,
    output logic [OFF_W-1:0] o_offset,
    output logic [7:0]       o_value,
    output logic [LEN_W-1:0] o_flen,
    output logic             o_done
);
    typedef enum logic {S_QUEUE, S_HEADER} t_state;

    t_state           r_state, n_state;
    logic [5:0]       r_idx, n_idx;
    logic [15:0]      r_ip_acc, n_ip_acc;
    logic [15:0]      r_udp_acc, n_udp_acc;
    logic [31:0]      r_dip, n_dip;
    logic [15:0]      r_dport, n_dport;
    logic [LEN_W-1:0] r_len, n_len;
    logic [15:0]      r_psum, n_psum;

    logic             r_valid, n_valid;
    logic [1:0]       r_status, n_status;
    logic [OFF_W-1:0] r_offset, n_offset;
    logic [7:0]       r_value, n_value;
    logic [LEN_W-1:0] r_flen, n_flen;
    logic             r_done, n_done;

    logic             adv, hdr_last;
    logic [15:0]      iplen, udplen, ip_ck, udp_ck;
    logic [15:0]      ip_term, udp_term;
    logic [47:0]      dmac;
    logic [HDR_BYTES*8-1:0] hdr;
    logic [5:0]       sel;
    logic [7:0]       hdr_byte;

    assign adv      = !r_valid || i_m_tready;
    assign hdr_last = (r_idx == HDR_LAST_IDX);

    // header fields from the snapshot and configuration
    assign iplen  = 16'd28 + 16'(r_len);
    assign udplen = 16'd8 + 16'(r_len);
    assign dmac   = (r_dip == IP_BROADCAST) ? MAC_BROADCAST : i_cfg.dst_mac;
    assign ip_ck  = ~r_ip_acc;
    assign udp_ck = (~r_udp_acc == 16'h0000) ? CKSUM_ZERO_TX : ~r_udp_acc;

    assign hdr = {dmac, i_cfg.src_mac, ETHERTYPE_IPV4,
                  IP_VER_IHL, 8'h00, iplen, 16'h0000, IP_FLAGS_DF,
                  IP_TTL, IP_PROTO_UDP, ip_ck, i_cfg.src_ip, r_dip,
                  i_cfg.src_port, r_dport, udplen, udp_ck};
    assign sel      = HDR_LAST_IDX - r_idx;
    assign hdr_byte = hdr[{sel, 3'b000} +: 8];

    // one checksum term per header byte; done well before the checksum bytes
    always_comb begin
        unique case (r_idx)
            6'd0:    begin ip_term = IP_SUM_FIXED;          udp_term = r_psum;              end
            6'd1:    begin ip_term = iplen;                 udp_term = i_cfg.src_ip[31:16]; end
            6'd2:    begin ip_term = i_cfg.src_ip[31:16];   udp_term = i_cfg.src_ip[15:0];  end
            6'd3:    begin ip_term = i_cfg.src_ip[15:0];    udp_term = r_dip[31:16];        end
            6'd4:    begin ip_term = r_dip[31:16];          udp_term = r_dip[15:0];         end
            6'd5:    begin ip_term = r_dip[15:0];           udp_term = 16'(IP_PROTO_UDP);   end
            6'd6:    begin ip_term = 16'h0000;              udp_term = udplen;              end
            6'd7:    begin ip_term = 16'h0000;              udp_term = i_cfg.src_port;      end
            6'd8:    begin ip_term = 16'h0000;              udp_term = r_dport;             end
            6'd9:    begin ip_term = 16'h0000;              udp_term = udplen;              end
            default: begin ip_term = 16'h0000;              udp_term = 16'h0000;            end
        endcase
    end

    // sequencing and output register
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_ip_acc  = r_ip_acc;
        n_udp_acc = r_udp_acc;
        n_dip     = r_dip;
        n_dport   = r_dport;
        n_len     = r_len;
        n_psum    = r_psum;
        n_valid   = r_valid && !i_m_tready;
        n_status  = r_status;
        n_offset  = r_offset;
        n_value   = r_value;
        n_flen    = r_flen;
        n_done    = r_done;
        o_pop     = 1'b0;

        if (adv) begin
            n_valid = 1'b0;
            if (r_state == S_HEADER) begin
                n_valid   = 1'b1;
                n_status  = ST_WRITE;
                n_offset  = OFF_W'(r_idx);
                n_value   = hdr_byte;
                n_flen    = hdr_last ? (LEN_W'(HDR_BYTES) + r_len) : '0;
                n_done    = hdr_last;
                n_ip_acc  = oc_add(r_ip_acc, ip_term);
                n_udp_acc = oc_add(r_udp_acc, udp_term);
                n_idx     = r_idx + 1'b1;
                if (hdr_last) begin
                    n_state = S_QUEUE;
                end
            end else if (!i_empty) begin
                o_pop    = 1'b1;
                n_status = ST_WRITE;
                n_offset = i_entry.offset;
                n_value  = i_entry.value;
                n_flen   = '0;
                n_done   = 1'b0;
                unique case (i_entry.op)
                    OP_WRITE: begin
                        n_valid = 1'b1;
                    end
                    OP_WRITE_HDR, OP_HDR: begin
                        n_valid   = (i_entry.op == OP_WRITE_HDR);
                        n_state   = S_HEADER;
                        n_idx     = '0;
                        n_ip_acc  = '0;
                        n_udp_acc = '0;
                        n_dip     = i_entry.dst_ip;
                        n_dport   = i_entry.dst_port;
                        n_len     = i_entry.len;
                        n_psum    = i_entry.psum;
                    end
                    OP_REJ_DIS: begin
                        n_valid  = 1'b1;
                        n_status = ST_NOT_ENABLED;
                        n_offset = '0;
                        n_value  = '0;
                        n_done   = 1'b1;
                    end
                    OP_REJ_LONG: begin
                        n_valid  = 1'b1;
                        n_status = ST_TOO_LONG;
                        n_offset = '0;
                        n_value  = '0;
                        n_done   = 1'b1;
                    end
                    default: begin
                        n_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_QUEUE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_idx     <= n_idx;
        r_ip_acc  <= n_ip_acc;
        r_udp_acc <= n_udp_acc;
        r_dip     <= n_dip;
        r_dport   <= n_dport;
        r_len     <= n_len;
        r_psum    <= n_psum;
        r_status  <= n_status;
        r_offset  <= n_offset;
        r_value   <= n_value;
        r_flen    <= n_flen;
        r_done    <= n_done;
    end

    assign o_m_tvalid = r_valid;
    assign o_status   = r_status;
    assign o_offset   = r_offset;
    assign o_value    = r_value;
    assign o_flen     = r_flen;
    assign o_done     = r_done;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEADER) |-> (r_idx <= HDR_LAST_IDX))
        else $error("header byte index out of range");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_done && r_status == ST_WRITE) |-> (r_offset == OFF_W'(HDR_LAST_IDX)))
        else $error("frame done on a write other than the last header byte");

    a_hdr_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_HEADER) |-> $past(o_pop))
        else $error("header started without a queued job");

    a_no_pop_in_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEADER) |-> !o_pop)
        else $error("queue popped during header burst");

endmodule

### rtl/core/udp_ipv4_frame_builder.sv
// Top level of the UDP/IPv4/Ethernet II frame builder: configuration
// registers, stream packing, front end, job queue and back end.
// Depends on udpfb_pkg, udpfb_front, udpfb_fifo and udpfb_back.
//
// Usage: configure enable, MACs, source IP and source port over the write
// port while idle. On the slave stream a request with tuser = 0 opens a frame
// (destination IP, port, payload length); tuser = 1 carries one payload byte.
// The master stream returns frame-buffer writes (offset, byte). Each payload
// byte gives one write at offset 42 + i; after the last byte (or straight
// after the start request for an empty payload) the 42 header bytes follow
// at offsets 0..41, the final one with tlast and the frame length. A rejected
// start gives a single result with the status in tuser and tlast set.
// A job from an accepted request is registered in the job queue and then in the
// output register. Throughput: one request per cycle while the queue is not
// full; a header burst occupies the back end, during which the front end
// keeps taking requests until the job queue of QUEUE_DEPTH entries fills.
// Reset clears the registers, the open frame and the queue. When the receiver
// stalls, the output register holds and the queue absorbs up to QUEUE_DEPTH
// jobs before s_axis_tready drops.
module udp_ipv4_frame_builder
    import udpfb_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = 1472,
    parameter int FRAME_MAX_BYTES   = 1514,
    parameter int QUEUE_DEPTH       = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // dest_ip[31:0], dest_port[47:32], payload_length[58:48],
    // payload_byte[66:59], zero pad[71:67]
    input  logic [71:0]           s_axis_tdata,
    // kind[0]
    input  logic                  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // write_offset[10:0], write_value[18:11], frame_length[29:19], zero[31:30]
    output logic [31:0]           m_axis_tdata,
    // status[1:0]
    output logic [1:0]            m_axis_tuser,
    // frame_done
    output logic                  m_axis_tlast
);
    localparam int EW = $bits(t_entry);

    t_cfg             r_cfg;
    logic             accept, push, pop, q_full, q_empty;
    t_entry           push_entry, pop_entry;
    logic [EW-1:0]    pop_data;
    logic [OFF_W-1:0] out_offset;
    logic [7:0]       out_value;
    logic [LEN_W-1:0] out_flen;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ENABLE:   r_cfg.enable   <= i_cfg_data[0];
                CFG_SRC_MAC:  r_cfg.src_mac  <= i_cfg_data;
                CFG_DST_MAC:  r_cfg.dst_mac  <= i_cfg_data;
                CFG_SRC_IP:   r_cfg.src_ip   <= i_cfg_data[31:0];
                CFG_SRC_PORT: r_cfg.src_port <= i_cfg_data[15:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    udpfb_front #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
        .FRAME_MAX_BYTES   (FRAME_MAX_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_kind           (s_axis_tuser),
        .i_dest_ip        (s_axis_tdata[31:0]),
        .i_dest_port      (s_axis_tdata[47:32]),
        .i_payload_length (s_axis_tdata[58:48]),
        .i_payload_byte   (s_axis_tdata[66:59]),
        .i_enable         (r_cfg.enable),
        .o_push           (push),
        .o_entry          (push_entry)
    );

    udpfb_fifo #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign pop_entry = t_entry'(pop_data);

    udpfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (q_empty),
        .i_entry    (pop_entry),
        .o_pop      (pop),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_status   (m_axis_tuser),
        .o_offset   (out_offset),
        .o_value    (out_value),
        .o_flen     (out_flen),
        .o_done     (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_flen, out_value, out_offset};

endmodule
